@@ rtl/rgbcp_pkg.sv @@
// rgbcp_pkg: shared types and constants for the rgb565 to client pixel converter
// no dependencies; imported by rgbcp_scale, rgbcp_pack and rgb565_to_client_pixel
`default_nettype none

package rgbcp_pkg;

    localparam int LIMIT_BITS   = 16;
    localparam int SCALED_BITS  = 16;
    localparam int POS_BITS     = 5;
    localparam int PBITS_BITS   = 6;
    localparam int PIXEL_BITS   = 32;
    localparam int COUNT_BITS   = 3;

    // supported client pixel widths, anything else is sent as 32 bits
    localparam logic [PBITS_BITS-1:0] PIXEL_WIDTH_8  = 6'd8;
    localparam logic [PBITS_BITS-1:0] PIXEL_WIDTH_16 = 6'd16;

    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = 3'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_TWO  = 3'd2;
    localparam logic [COUNT_BITS-1:0] COUNT_FOUR = 3'd4;

    typedef enum logic [2:0] {
        REG_PIXEL_BITS     = 3'd0,
        REG_BYTE_ORDER_BIG = 3'd1,
        REG_RED_LIMIT      = 3'd2,
        REG_GREEN_LIMIT    = 3'd3,
        REG_BLUE_LIMIT     = 3'd4,
        REG_RED_POSITION   = 3'd5,
        REG_GREEN_POSITION = 3'd6,
        REG_BLUE_POSITION  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PBITS_BITS-1:0] pixel_bits;
        logic                  byte_order_big;
        logic [POS_BITS-1:0]   red_position;
        logic [POS_BITS-1:0]   green_position;
        logic [POS_BITS-1:0]   blue_position;
    } pack_cfg_t;

endpackage

`default_nettype wire

@@ rtl/rgbcp_scale.sv @@
// rgbcp_scale: three-stage rescale of one color component, (c*limit+half)/(2^n-1)
// depends on rgbcp_pkg; division is a reciprocal multiply plus one correction step
`default_nettype none

module rgbcp_scale
    import rgbcp_pkg::*;
#(
    parameter int CompBits = 5
)(
    input  wire logic                   clk,
    input  wire logic [CompBits-1:0]    comp,
    input  wire logic [LIMIT_BITS-1:0]  limit,
    output logic      [SCALED_BITS-1:0] scaled
);

    localparam int XBits     = CompBits + LIMIT_BITS;
    localparam int Divisor   = (1 << CompBits) - 1;
    localparam int Half      = (1 << (CompBits - 1)) - 1;
    localparam int Shift     = XBits + 6;
    localparam int RecipBits = Shift - CompBits + 1;
    localparam longint RecipL = (64'sd1 <<< Shift) / Divisor;
    localparam logic [RecipBits-1:0] Recip = RecipBits'(RecipL);
    localparam int ProdBits  = XBits + RecipBits;

    logic [XBits-1:0]       x_reg, x_next;
    logic [XBits-1:0]       x2_reg;
    logic [SCALED_BITS-1:0] q_est_reg, q_est_next;
    logic [SCALED_BITS-1:0] q_reg, q_next;
    logic [ProdBits-1:0]    recip_prod;
    logic [XBits-1:0]       q_times_div;
    logic [XBits-1:0]       rem;

    // stage 1: product plus rounding half
    assign x_next = XBits'(comp) * XBits'(limit) + XBits'(Half);

    // stage 2: quotient estimate, equal to the true quotient or one short
    assign recip_prod = ProdBits'(x_reg) * ProdBits'(Recip);
    assign q_est_next = recip_prod[Shift +: SCALED_BITS];

    // stage 3: remainder check fixes the estimate
    assign q_times_div = (XBits'(q_est_reg) << CompBits) - XBits'(q_est_reg);
    assign rem         = x2_reg - q_times_div;
    assign q_next      = (rem >= XBits'(Divisor)) ? q_est_reg + 1'b1 : q_est_reg;

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        x2_reg    <= x_reg;
        q_est_reg <= q_est_next;
        q_reg     <= q_next;
    end

    assign scaled = q_reg;

endmodule

`default_nettype wire

@@ rtl/rgbcp_pack.sv @@
// rgbcp_pack: places the scaled components and orders the bytes for sending
// depends on rgbcp_pkg; one register stage that drives the result ports
`default_nettype none

module rgbcp_pack
    import rgbcp_pkg::*;
(
    input  wire logic                   clk,
    input  wire pack_cfg_t              cfg,
    input  wire logic [SCALED_BITS-1:0] red,
    input  wire logic [SCALED_BITS-1:0] green,
    input  wire logic [SCALED_BITS-1:0] blue,
    output logic      [PIXEL_BITS-1:0]  wire_bytes,
    output logic      [COUNT_BITS-1:0]  byte_count
);

    logic [PIXEL_BITS-1:0] pixel;
    logic [PIXEL_BITS-1:0] wire_reg, wire_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // bits shifted past bit 31 drop out
    assign pixel = (PIXEL_BITS'(red)   << cfg.red_position)
                 | (PIXEL_BITS'(green) << cfg.green_position)
                 | (PIXEL_BITS'(blue)  << cfg.blue_position);

    always_comb
    begin
        if (cfg.pixel_bits == PIXEL_WIDTH_8) begin
            count_next = COUNT_ONE;
        end else if (cfg.pixel_bits == PIXEL_WIDTH_16) begin
            count_next = COUNT_TWO;
        end else begin
            count_next = COUNT_FOUR;
        end
    end

    always_comb
    begin
        case (count_next)
            COUNT_ONE: wire_next = {24'd0, pixel[7:0]};
            COUNT_TWO:
            begin
                if (cfg.byte_order_big) begin
                    wire_next = {16'd0, pixel[7:0], pixel[15:8]};
                end else begin
                    wire_next = {16'd0, pixel[15:0]};
                end
            end
            default:
            begin
                if (cfg.byte_order_big) begin
                    wire_next = {pixel[7:0], pixel[15:8], pixel[23:16], pixel[31:24]};
                end else begin
                    wire_next = pixel;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        wire_reg  <= wire_next;
        count_reg <= count_next;
    end

    assign wire_bytes = wire_reg;
    assign byte_count = count_reg;

endmodule

`default_nettype wire

@@ rtl/rgb565_to_client_pixel.sv @@
// rgb565_to_client_pixel: rgb565 to client true-colour pixel converter, top level
// depends on rgbcp_pkg, rgbcp_scale and rgbcp_pack
//
//  channel   handshake                  payload
//  input     start, busy                source_pixel[15:0]
//  result    done (one-cycle strobe)    wire_bytes[31:0], byte_count[2:0]
//  config    write_enable               write_index[2:0], write_data[15:0]
//
// one pixel a cycle; each result is registered through the scale pipe
// (multiply, reciprocal multiply, correction)
// followed by the byte packing register
// busy stays low: the pipe never stalls and the receiver cannot stall
// reset clears the valid bits and loads the default 16-bit 5:6:5 format
`default_nettype none

module rgb565_to_client_pixel
    import rgbcp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [15:0]            source_pixel,
    output logic                        done,
    output logic      [PIXEL_BITS-1:0]  wire_bytes,
    output logic      [COUNT_BITS-1:0]  byte_count,
    input  wire logic                   write_enable,
    input  wire logic [2:0]             write_index,
    input  wire logic [LIMIT_BITS-1:0]  write_data
);

    localparam int Stages = 4;

    logic [PBITS_BITS-1:0] pixel_bits_reg;
    logic                  byte_order_big_reg;
    logic [LIMIT_BITS-1:0] red_limit_reg;
    logic [LIMIT_BITS-1:0] green_limit_reg;
    logic [LIMIT_BITS-1:0] blue_limit_reg;
    logic [POS_BITS-1:0]   red_position_reg;
    logic [POS_BITS-1:0]   green_position_reg;
    logic [POS_BITS-1:0]   blue_position_reg;

    logic [Stages-1:0]      valid_reg, valid_next;
    logic                   accept;
    logic [SCALED_BITS-1:0] red_scaled;
    logic [SCALED_BITS-1:0] green_scaled;
    logic [SCALED_BITS-1:0] blue_scaled;
    pack_cfg_t              pack_cfg;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[Stages-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pixel_bits_reg     <= PIXEL_WIDTH_16;
            byte_order_big_reg <= 1'b0;
            red_limit_reg      <= 16'd31;
            green_limit_reg    <= 16'd63;
            blue_limit_reg     <= 16'd31;
            red_position_reg   <= 5'd11;
            green_position_reg <= 5'd5;
            blue_position_reg  <= 5'd0;
        end else if (write_enable) begin
            unique case (cfg_reg_t'(write_index))
                REG_PIXEL_BITS:     pixel_bits_reg     <= write_data[PBITS_BITS-1:0];
                REG_BYTE_ORDER_BIG: byte_order_big_reg <= write_data[0];
                REG_RED_LIMIT:      red_limit_reg      <= write_data;
                REG_GREEN_LIMIT:    green_limit_reg    <= write_data;
                REG_BLUE_LIMIT:     blue_limit_reg     <= write_data;
                REG_RED_POSITION:   red_position_reg   <= write_data[POS_BITS-1:0];
                REG_GREEN_POSITION: green_position_reg <= write_data[POS_BITS-1:0];
                REG_BLUE_POSITION:  blue_position_reg  <= write_data[POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    rgbcp_scale #(.CompBits(5)) u_scale_red (
        .clk    (clk),
        .comp   (source_pixel[15:11]),
        .limit  (red_limit_reg),
        .scaled (red_scaled)
    );

    rgbcp_scale #(.CompBits(6)) u_scale_green (
        .clk    (clk),
        .comp   (source_pixel[10:5]),
        .limit  (green_limit_reg),
        .scaled (green_scaled)
    );

    rgbcp_scale #(.CompBits(5)) u_scale_blue (
        .clk    (clk),
        .comp   (source_pixel[4:0]),
        .limit  (blue_limit_reg),
        .scaled (blue_scaled)
    );

    assign pack_cfg.pixel_bits     = pixel_bits_reg;
    assign pack_cfg.byte_order_big = byte_order_big_reg;
    assign pack_cfg.red_position   = red_position_reg;
    assign pack_cfg.green_position = green_position_reg;
    assign pack_cfg.blue_position  = blue_position_reg;

    rgbcp_pack u_pack (
        .clk        (clk),
        .cfg        (pack_cfg),
        .red        (red_scaled),
        .green      (green_scaled),
        .blue       (blue_scaled),
        .wire_bytes (wire_bytes),
        .byte_count (byte_count)
    );

    assign done = valid_reg[Stages-1];

endmodule

`default_nettype wire
